>>> design/selectable_channel_seven_segment_display_core_assert.svh
// Assertion macros shared by the display core.
`ifndef SELECTABLE_CHANNEL_SEVEN_SEGMENT_DISPLAY_CORE_ASSERT_SVH
`define SELECTABLE_CHANNEL_SEVEN_SEGMENT_DISPLAY_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SCSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("display core assertion failed");

// Next-cycle implication, checked out of reset.
`define SCSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("display core assertion failed");

`endif

>>> design/scsd_pkg.sv
`timescale 1ns / 1ps

package scsd_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SCAN_PERIOD    = 2'd0,
    CFG_REFRESH_PERIOD = 2'd1,
    CFG_SAMPLE_PERIOD  = 2'd2
  } cfg_index_t;

  localparam logic [7:0] SCAN_PERIOD_RST    = 8'd5;
  localparam logic [9:0] REFRESH_PERIOD_RST = 10'd500;
  localparam logic [7:0] SAMPLE_PERIOD_RST  = 8'd10;

  localparam logic [7:0] SEG_BLANK  = 8'hFF;
  localparam logic [3:0] DIGIT_NONE = 4'hF;
  localparam logic [2:0] CHAN_NONE  = 3'd0;
  localparam logic [2:0] CHAN_FIRST = 3'd1;
  localparam logic [2:0] CHAN_LAST  = 3'd4;

  // Four decimal digits, index 0 is the ones digit
  typedef logic [3:0][3:0] digits_t;

  // Active-low segment code of a decimal digit; anything above nine is blank
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hC0;
      4'd1:    s = 8'hF9;
      4'd2:    s = 8'hA4;
      4'd3:    s = 8'hB0;
      4'd4:    s = 8'h99;
      4'd5:    s = 8'h92;
      4'd6:    s = 8'h82;
      4'd7:    s = 8'hF8;
      4'd8:    s = 8'h80;
      4'd9:    s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Floor of p / 1023 for p below about one million: p = 1024a + b = 1023a + (a + b)
  function automatic logic [9:0] div1023(input logic [19:0] p);
    logic [10:0] s;
    s = {1'b0, p[19:10]} + {1'b0, p[9:0]};
    return p[19:10] + 10'(s >= 11'd1023);
  endfunction

  // x * 5000 / 1023 = 5x - ceil(115x / 1023)
  function automatic logic [12:0] scale_voltage(input logic [9:0] x);
    logic [19:0] r;
    logic [9:0]  c;
    r = 20'(x) * 20'd115;
    c = div1023(r + 20'd1022);
    return (13'(x) * 13'd5) - 13'(c);
  endfunction

  // (x * 5000 / 1023) / 10 collapses to x * 500 / 1023
  function automatic logic [12:0] scale_temperature(input logic [9:0] x);
    return 13'(div1023(20'(x) * 20'd500));
  endfunction

  // Split a value up to 8191 into decimal digits by reciprocal multiplies
  function automatic digits_t split_value(input logic [12:0] v);
    logic [26:0] p10;
    logic [26:0] p100;
    logic [26:0] p1000;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [12:0] r1;
    logic [9:0]  r10;
    logic [6:0]  r100;
    digits_t     d;
    p10   = 27'(v) * 27'd6554;
    p100  = 27'(v) * 27'd5243;
    p1000 = 27'(v) * 27'd8389;
    q10   = p10[25:16];
    q100  = p100[25:19];
    q1000 = p1000[26:23];
    r1    = v - 13'(q10) * 13'd10;
    r10   = q10 - 10'(q100) * 10'd10;
    r100  = q100 - 7'(q1000) * 7'd10;
    d[0]  = r1[3:0];
    d[1]  = r10[3:0];
    d[2]  = r100[3:0];
    d[3]  = q1000;
    return d;
  endfunction

endpackage

>>> design/selectable_channel_seven_segment_display_core.sv
`timescale 1ns / 1ps
// Four-digit multiplexed seven-segment display driver with a selectable channel.
// Input stream (in_*): one word per millisecond tick, carrying the button level
// and four 10-bit converter readings. Each accepted word advances the scan,
// refresh and sample counters and may drive the next digit, step the channel on
// a fresh button press, refresh the shown digits, or capture and scale readings.
// Output stream (out_*): one word per input word with the active-low segment
// pattern and digit enables on out_tdata and the selected channel on out_tuser.
// Configuration (cfg_*): index 0 scan period, 1 refresh period, 2 sample period;
// other indexes are dropped. cfg_ready is always high; write only while idle.
// The result word is registered, valid in the cycle after its word is taken.
// Throughput: one word per cycle unless stalled; all work is a combinational
// pass from the input word and state registers to the state and output register.
// Reset (synchronous, rst_n low) restores the default periods, blanks the
// display, clears the counters and sets channel 0, which shows 0000.
// When the receiver stalls, the result word holds and in_tready drops once it
// is full; in_tready stays high while the pending word is taken in that cycle.
module selectable_channel_seven_segment_display_core (
  input  logic        clk,
  input  logic        rst_n,
  // bit 0 button_low, [10:1] adc_voltage_a, [20:11] adc_voltage_b,
  // [30:21] adc_voltage_c, [40:31] adc_temperature, [47:41] zero
  input  logic [47:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] segment_pattern, [11:8] digit_enables, [15:12] zero
  output logic [15:0] out_tdata,
  // [2:0] selected_channel
  output logic [2:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  logic        in_accept;
  logic        pressed;

  logic [7:0]  scan_period_r;
  logic [9:0]  refresh_period_r;
  logic [7:0]  sample_period_r;

  logic [8:0]  scan_elapsed_r,    scan_elapsed_nxt;
  logic [10:0] refresh_elapsed_r, refresh_elapsed_nxt;
  logic [8:0]  sample_elapsed_r,  sample_elapsed_nxt;
  logic [2:0]  channel_r,         channel_nxt;
  logic        held_r,            held_nxt;
  logic [12:0] scaled_r [4];
  logic [12:0] scaled_nxt [4];
  scsd_pkg::digits_t digits_r,    digits_nxt;
  logic [1:0]  scan_pos_r,        scan_pos_nxt;
  logic [7:0]  segment_r,         segment_nxt;
  logic [3:0]  enable_r,          enable_nxt;
  logic        out_valid_r;

  logic [8:0]  scan_bump;
  logic [10:0] refresh_bump;
  logic [8:0]  sample_bump;
  logic        scan_fire;
  logic        refresh_fire;
  logic        sample_fire;
  logic        advance;
  logic [2:0]  chan_step;
  logic [2:0]  chan_new;
  logic [2:0]  chan_off;
  logic [1:0]  sel_idx;

  // Handshakes: the result register frees up when it is taken this cycle
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, enable_r, segment_r};
  assign out_tuser  = channel_r;
  assign cfg_ready  = 1'b1;

  assign pressed = in_tdata[0];

  // Saturating tick counters and their events
  assign scan_bump    = (scan_elapsed_r == '1) ? scan_elapsed_r : scan_elapsed_r + 9'd1;
  assign refresh_bump = (refresh_elapsed_r == '1) ? refresh_elapsed_r
                                                  : refresh_elapsed_r + 11'd1;
  assign sample_bump  = (sample_elapsed_r == '1) ? sample_elapsed_r : sample_elapsed_r + 9'd1;
  assign scan_fire    = scan_bump > {1'b0, scan_period_r};
  assign refresh_fire = refresh_bump > {1'b0, refresh_period_r};
  assign sample_fire  = sample_bump > {1'b0, sample_period_r};

  // Channel step on a fresh press at refresh time
  assign advance   = refresh_fire && pressed && !held_r;
  assign chan_step = (channel_r >= scsd_pkg::CHAN_LAST) ? scsd_pkg::CHAN_FIRST
                                                        : channel_r + 3'd1;
  assign chan_new  = advance ? chan_step : channel_r;
  assign chan_off  = chan_new - scsd_pkg::CHAN_FIRST;
  assign sel_idx   = chan_off[1:0];

  // Next state for one accepted word
  always_comb begin
    scan_elapsed_nxt    = scan_elapsed_r;
    refresh_elapsed_nxt = refresh_elapsed_r;
    sample_elapsed_nxt  = sample_elapsed_r;
    channel_nxt         = channel_r;
    held_nxt            = held_r;
    scaled_nxt          = scaled_r;
    digits_nxt          = digits_r;
    scan_pos_nxt        = scan_pos_r;
    segment_nxt         = segment_r;
    enable_nxt          = enable_r;
    if (in_accept) begin
      scan_elapsed_nxt    = scan_fire ? '0 : scan_bump;
      refresh_elapsed_nxt = refresh_fire ? '0 : refresh_bump;
      sample_elapsed_nxt  = sample_fire ? '0 : sample_bump;
      held_nxt            = advance || (pressed && held_r);
      channel_nxt         = chan_new;
      // Drive the next digit
      if (scan_fire) begin
        segment_nxt  = scsd_pkg::seg_code(digits_r[scan_pos_r]);
        enable_nxt   = ~(4'd1 << scan_pos_r);
        scan_pos_nxt = scan_pos_r + 2'd1;
      end
      // Refresh the shown value once a channel is chosen
      if (refresh_fire && chan_new != scsd_pkg::CHAN_NONE) begin
        digits_nxt = scsd_pkg::split_value(scaled_r[sel_idx]);
      end
      // Capture and scale the readings
      if (sample_fire) begin
        scaled_nxt[0] = scsd_pkg::scale_voltage(in_tdata[10:1]);
        scaled_nxt[1] = scsd_pkg::scale_voltage(in_tdata[20:11]);
        scaled_nxt[2] = scsd_pkg::scale_voltage(in_tdata[30:21]);
        scaled_nxt[3] = scsd_pkg::scale_temperature(in_tdata[40:31]);
      end
    end
  end

  // State, configuration and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_period_r     <= scsd_pkg::SCAN_PERIOD_RST;
      refresh_period_r  <= scsd_pkg::REFRESH_PERIOD_RST;
      sample_period_r   <= scsd_pkg::SAMPLE_PERIOD_RST;
      scan_elapsed_r    <= '0;
      refresh_elapsed_r <= '0;
      sample_elapsed_r  <= '0;
      channel_r         <= scsd_pkg::CHAN_NONE;
      held_r            <= 1'b0;
      scaled_r          <= '{default: '0};
      digits_r          <= '0;
      scan_pos_r        <= '0;
      segment_r         <= scsd_pkg::SEG_BLANK;
      enable_r          <= scsd_pkg::DIGIT_NONE;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          scsd_pkg::CFG_SCAN_PERIOD:    scan_period_r    <= cfg_data[7:0];
          scsd_pkg::CFG_REFRESH_PERIOD: refresh_period_r <= cfg_data;
          scsd_pkg::CFG_SAMPLE_PERIOD:  sample_period_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
      scan_elapsed_r    <= scan_elapsed_nxt;
      refresh_elapsed_r <= refresh_elapsed_nxt;
      sample_elapsed_r  <= sample_elapsed_nxt;
      channel_r         <= channel_nxt;
      held_r            <= held_nxt;
      scaled_r          <= scaled_nxt;
      digits_r          <= digits_nxt;
      scan_pos_r        <= scan_pos_nxt;
      segment_r         <= segment_nxt;
      enable_r          <= enable_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`include "selectable_channel_seven_segment_display_core_assert.svh"

  `SCSD_ASSERT_NOW(a_one_digit_on, clk, rst_n, 1'b1, $onehot0(~enable_r))
  `SCSD_ASSERT_NOW(a_held_has_channel, clk, rst_n, held_r, channel_r != scsd_pkg::CHAN_NONE)
  `SCSD_ASSERT_NOW(a_channel_range, clk, rst_n, 1'b1, channel_r <= scsd_pkg::CHAN_LAST)
  `SCSD_ASSERT_NEXT(a_word_lands, clk, rst_n, in_accept, out_valid_r)

endmodule
